// ===== src/nls_pkg.sv =====
// Shared types, codes and character classes for the numeric literal scanner.
package nls_pkg;

  localparam int unsigned LENGTH_LIMIT_DEF = 4095;
  localparam int unsigned LenW = 12;
  localparam int unsigned LenMax = 4095;

  typedef enum logic [1:0] {
    KIND_INT = 2'd0,
    KIND_FLOAT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_UPPER_PREFIX = 3'd1,
    ERR_BASE_DIGIT = 3'd2,
    ERR_INT_SUFFIX = 3'd3,
    ERR_UNDERSCORE = 3'd4,
    ERR_NO_DIGIT = 3'd5,
    ERR_TRAIL_UNDERSCORE = 3'd6,
    ERR_SUFFIX = 3'd7
  } err_e;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [3:0] SFX_NONE = 4'd0;
  localparam logic [3:0] SFX_U8 = 4'd1;
  localparam logic [3:0] SFX_U16 = 4'd2;
  localparam logic [3:0] SFX_U32 = 4'd3;
  localparam logic [3:0] SFX_U64 = 4'd4;
  localparam logic [3:0] SFX_I8 = 4'd5;
  localparam logic [3:0] SFX_I16 = 4'd6;
  localparam logic [3:0] SFX_I32 = 4'd7;
  localparam logic [3:0] SFX_I64 = 4'd8;
  localparam logic [3:0] SFX_F16 = 4'd9;
  localparam logic [3:0] SFX_F32 = 4'd10;
  localparam logic [3:0] SFX_F64 = 4'd11;

  // suffix matcher progress
  localparam logic [4:0] SP_NONE = 5'd0;
  localparam logic [4:0] SP_BAD = 5'd1;
  localparam logic [4:0] SP_U = 5'd2;
  localparam logic [4:0] SP_I = 5'd3;
  localparam logic [4:0] SP_F = 5'd4;
  localparam logic [4:0] SP_U1 = 5'd5;
  localparam logic [4:0] SP_U3 = 5'd6;
  localparam logic [4:0] SP_U6 = 5'd7;
  localparam logic [4:0] SP_I1 = 5'd8;
  localparam logic [4:0] SP_I3 = 5'd9;
  localparam logic [4:0] SP_I6 = 5'd10;
  localparam logic [4:0] SP_F1 = 5'd11;
  localparam logic [4:0] SP_F3 = 5'd12;
  localparam logic [4:0] SP_F6 = 5'd13;
  localparam logic [4:0] SP_DONE = 5'd16;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0]      ret;
    logic [LenW-1:0] len;
    logic [3:0]      sfx;
    logic [1:0]      radix;
    err_e            err;
    kind_e           kind;
  } res_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_dec(c) || (c == "_");
  endfunction

  function automatic logic digit_ok(input logic based, input logic [1:0] radix,
                                    input logic [7:0] c);
    logic ok;
    if (!based) begin
      ok = is_dec(c);
    end else if (radix == RADIX_BIN) begin
      ok = (c == "0") || (c == "1");
    end else if (radix == RADIX_OCT) begin
      ok = (c >= "0") && (c <= "7");
    end else begin
      ok = is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    end
    return ok;
  endfunction

  function automatic logic [4:0] suffix_start(input logic [7:0] c);
    logic [4:0] p;
    case (c)
      "u": p = SP_U;
      "i": p = SP_I;
      "f": p = SP_F;
      default: p = SP_BAD;
    endcase
    return p;
  endfunction

  function automatic logic [4:0] suffix_next(input logic [4:0] p, input logic [7:0] c);
    logic [4:0] n;
    n = SP_BAD;
    case (p)
      SP_U: begin
        if (c == "8") n = SP_DONE + 5'(SFX_U8);
        else if (c == "1") n = SP_U1;
        else if (c == "3") n = SP_U3;
        else if (c == "6") n = SP_U6;
      end
      SP_I: begin
        if (c == "8") n = SP_DONE + 5'(SFX_I8);
        else if (c == "1") n = SP_I1;
        else if (c == "3") n = SP_I3;
        else if (c == "6") n = SP_I6;
      end
      SP_F: begin
        if (c == "1") n = SP_F1;
        else if (c == "3") n = SP_F3;
        else if (c == "6") n = SP_F6;
      end
      SP_U1: if (c == "6") n = SP_DONE + 5'(SFX_U16);
      SP_U3: if (c == "2") n = SP_DONE + 5'(SFX_U32);
      SP_U6: if (c == "4") n = SP_DONE + 5'(SFX_U64);
      SP_I1: if (c == "6") n = SP_DONE + 5'(SFX_I16);
      SP_I3: if (c == "2") n = SP_DONE + 5'(SFX_I32);
      SP_I6: if (c == "4") n = SP_DONE + 5'(SFX_I64);
      SP_F1: if (c == "6") n = SP_DONE + 5'(SFX_F16);
      SP_F3: if (c == "2") n = SP_DONE + 5'(SFX_F32);
      SP_F6: if (c == "4") n = SP_DONE + 5'(SFX_F64);
      default: n = SP_BAD;
    endcase
    return n;
  endfunction

endpackage

// ===== src/nls_in_stage.sv =====
// Input register that holds one accepted byte until the scanner core takes it.
module nls_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  nls_pkg::item_t in_item_i,
  output logic          item_valid_o,
  output nls_pkg::item_t item_o,
  input  logic          take_i
);
  import nls_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d = in_valid_i ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o = item_q;

endmodule

// ===== src/nls_core.sv =====
// Scanner state machine: one byte per step, result computed in the same step.
module nls_core #(
  parameter int unsigned LENGTH_LIMIT = nls_pkg::LENGTH_LIMIT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  nls_pkg::item_t item_i,
  output logic           res_valid_o,
  output nls_pkg::res_t  res_o
);
  import nls_pkg::*;

  localparam int unsigned CntW = $clog2(LENGTH_LIMIT + 1);

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ZERO = 4'd1,
    PH_BASED = 4'd2,
    PH_INT = 4'd3,
    PH_DOT = 4'd4,
    PH_FRAC = 4'd5,
    PH_EXP = 4'd6,
    PH_EXPD = 4'd7,
    PH_SUFFIX = 4'd8
  } phase_e;

  phase_e          phase_q, phase_d, run_ph;
  logic [1:0]      radix_q, radix_d;
  logic            seen_q, seen_d, und_q, und_d, flt_q, flt_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_base;
  logic [CntW:0]   cnt_sum;
  logic [4:0]      sp_q, sp_d;
  logic [1:0]      add_n;
  logic            emit, run, tail, try_exp;
  kind_e           kind;
  err_e            err;
  logic [3:0]      sfx, code;
  logic [1:0]      ret;
  logic [7:0]      c;
  logic [31:0]     cnt_ext;

  assign c = item_i.data;
  assign code = (sp_q > SP_DONE) ? 4'(sp_q - SP_DONE) : SFX_NONE;

  always_comb begin
    phase_d = phase_q;
    radix_d = radix_q;
    seen_d = seen_q;
    und_d = und_q;
    flt_d = flt_q;
    sp_d = sp_q;
    add_n = 2'd0;
    emit = 1'b0;
    kind = KIND_INT;
    err = ERR_NONE;
    sfx = SFX_NONE;
    ret = 2'd1;
    run = 1'b0;
    run_ph = phase_q;
    tail = 1'b0;
    try_exp = 1'b0;

    if (item_i.first) begin
      radix_d = RADIX_DEC;
      seen_d = 1'b0;
      und_d = 1'b0;
      flt_d = 1'b0;
      sp_d = SP_NONE;
      if (!is_dec(c)) begin
        emit = 1'b1;
        kind = KIND_REJECT;
        err = ERR_NO_DIGIT;
      end else begin
        seen_d = 1'b1;
        add_n = 2'd1;
        phase_d = (c == "0") ? PH_ZERO : PH_INT;
      end
    end else begin
      case (phase_q)
        PH_IDLE: phase_d = PH_IDLE;
        PH_ZERO: begin
          if (c == "X" || c == "O" || c == "B") begin
            add_n = 2'd1;
            emit = 1'b1;
            kind = KIND_REJECT;
            err = ERR_UPPER_PREFIX;
            ret = 2'd0;
          end else if (c == "x" || c == "o" || c == "b") begin
            add_n = 2'd1;
            radix_d = (c == "b") ? RADIX_BIN : (c == "o") ? RADIX_OCT : RADIX_HEX;
            seen_d = 1'b0;
            und_d = 1'b0;
            phase_d = PH_BASED;
          end else begin
            phase_d = PH_INT;
            run = 1'b1;
            run_ph = PH_INT;
          end
        end
        PH_DOT: begin
          if (is_dec(c)) begin
            add_n = 2'd2;
            flt_d = 1'b1;
            seen_d = 1'b1;
            und_d = 1'b0;
            phase_d = PH_FRAC;
          end else begin
            emit = 1'b1;
            kind = flt_q ? KIND_FLOAT : KIND_INT;
            ret = 2'd2;
          end
        end
        PH_EXP: begin
          phase_d = PH_EXPD;
          if (c == "+" || c == "-") begin
            add_n = 2'd1;
          end else begin
            run = 1'b1;
            run_ph = PH_EXPD;
          end
        end
        PH_SUFFIX: begin
          if (is_word(c)) begin
            sp_d = suffix_next(sp_q, c);
            add_n = 2'd1;
          end else begin
            emit = 1'b1;
            if (radix_q != RADIX_DEC) begin
              if (code >= SFX_U8 && code <= SFX_I64) begin
                sfx = code;
              end else begin
                kind = KIND_REJECT;
                err = ERR_INT_SUFFIX;
              end
            end else if (code >= SFX_F16 && code <= SFX_F64) begin
              kind = KIND_FLOAT;
              sfx = code;
            end else if (code >= SFX_U8 && code <= SFX_I64 && !flt_q) begin
              sfx = code;
            end else begin
              kind = KIND_REJECT;
              err = ERR_SUFFIX;
            end
          end
        end
        PH_BASED, PH_INT, PH_FRAC, PH_EXPD: run = 1'b1;
        default: phase_d = PH_IDLE;
      endcase

      if (run) begin
        if (digit_ok(run_ph == PH_BASED, radix_q, c)) begin
          seen_d = 1'b1;
          und_d = 1'b0;
          add_n = 2'd1;
        end else if (c == "_") begin
          if (!seen_q || und_q) begin
            emit = 1'b1;
            kind = KIND_REJECT;
            err = ERR_UNDERSCORE;
          end else begin
            und_d = 1'b1;
            add_n = 2'd1;
          end
        end else if (!seen_q) begin
          emit = 1'b1;
          kind = KIND_REJECT;
          err = ERR_NO_DIGIT;
        end else if (und_q) begin
          emit = 1'b1;
          kind = KIND_REJECT;
          err = ERR_TRAIL_UNDERSCORE;
        end else if (run_ph == PH_BASED) begin
          if (is_dec(c)) begin
            emit = 1'b1;
            kind = KIND_REJECT;
            err = ERR_BASE_DIGIT;
          end else begin
            tail = 1'b1;
          end
        end else if (run_ph == PH_INT) begin
          if (c == ".") phase_d = PH_DOT;
          else try_exp = 1'b1;
        end else if (run_ph == PH_FRAC) begin
          try_exp = 1'b1;
        end else begin
          tail = 1'b1;
        end
      end

      if (try_exp) begin
        if (c == "e" || c == "E") begin
          flt_d = 1'b1;
          add_n = 2'd1;
          seen_d = 1'b0;
          und_d = 1'b0;
          phase_d = PH_EXP;
        end else begin
          tail = 1'b1;
        end
      end

      if (tail) begin
        if (is_alpha(c)) begin
          sp_d = suffix_start(c);
          add_n = 2'd1;
          phase_d = PH_SUFFIX;
        end else begin
          emit = 1'b1;
          kind = flt_q ? KIND_FLOAT : KIND_INT;
        end
      end
    end

    if (emit) begin
      phase_d = PH_IDLE;
    end
  end

  // saturating length
  assign cnt_base = item_i.first ? '0 : cnt_q;
  assign cnt_sum = {1'b0, cnt_base} + (CntW + 1)'(add_n);
  assign cnt_d = (cnt_sum > (CntW + 1)'(LENGTH_LIMIT)) ? CntW'(LENGTH_LIMIT)
                                                       : cnt_sum[CntW-1:0];
  assign cnt_ext = 32'(cnt_d);

  always_comb begin
    res_o.kind = kind;
    res_o.err = err;
    res_o.radix = (kind == KIND_REJECT && err == ERR_UPPER_PREFIX) ? RADIX_DEC : radix_d;
    res_o.sfx = sfx;
    res_o.len = (cnt_ext > 32'(LenMax)) ? LenW'(LenMax) : cnt_ext[LenW-1:0];
    res_o.ret = ret;
  end

  assign res_valid_o = step_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      radix_q <= RADIX_DEC;
      seen_q <= 1'b0;
      und_q <= 1'b0;
      flt_q <= 1'b0;
      cnt_q <= '0;
      sp_q <= SP_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      seen_q <= seen_d;
      und_q <= und_d;
      flt_q <= flt_d;
      cnt_q <= cnt_d;
      sp_q <= sp_d;
    end
  end

endmodule

// ===== src/numeric_literal_scanner.sv =====
// Numeric literal scanner top level: input register, scanner core, result register.
// Usage:
//   Bytes of source text arrive on the s_axis channel, one request per byte.
//   s_axis_tuser marks the first byte of a literal; a byte of 0 is end of text.
//   Bytes that arrive while no literal is open and without the mark are dropped.
//   When a literal ends, one result request leaves on m_axis: its kind on tuser,
//   error code, radix, suffix, saturated length and the count of received bytes
//   that the lexer must feed again (the ending byte, and a held dot if any).
//   Most bytes give no result.
// Timing:
//   An accepted byte is registered in the input register and scanned from there;
//   a result it causes is registered in the result register and shown on m_axis.
//   Throughput is one byte per cycle unless a result stalls on m_axis: a byte's
//   scan is one pass through the state update between input and result registers.
// Reset and stalls:
//   Reset empties both registers and returns the scanner to idle.
//   While m_axis_tready is low with a result shown, the byte in the input
//   register waits and s_axis_tready drops once that register is full.
module numeric_literal_scanner #(
  parameter int unsigned LENGTH_LIMIT = nls_pkg::LENGTH_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] next_byte
  input  logic        s_axis_tuser,   // [0] first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] error_kind, [4:3] radix,
                                      // [8:5] type_suffix, [20:9] literal_length,
                                      // [22:21] bytes_returned, [23] zero
  output logic [1:0]  m_axis_tuser    // [1:0] literal_kind
);
  import nls_pkg::*;

  item_t in_item, item;
  logic  item_valid, step, res_valid;
  res_t  res, res_q;
  logic  out_valid_q, out_valid_d;

  assign in_item.first = s_axis_tuser;
  assign in_item.data = s_axis_tdata;

  nls_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (step)
  );

  assign step = item_valid && (!out_valid_q || m_axis_tready);

  nls_core #(
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_d = res_valid ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = res_q.kind;
  assign m_axis_tdata = {1'b0, res_q.ret, res_q.len, res_q.sfx, res_q.radix, res_q.err};

endmodule
